// ===== design/hhlp_pkg.sv =====
// Shared types and constants of the HTTP header line parser.
package hhlp_pkg;

    localparam int DATA_WIDTH     = 8;
    localparam int CONSUMED_WIDTH = 16;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_AW       = $clog2(QUEUE_DEPTH);

    localparam logic [DATA_WIDTH-1:0] CH_COLON = 8'h3A;
    localparam logic [DATA_WIDTH-1:0] CH_CR    = 8'h0D;
    localparam logic [DATA_WIDTH-1:0] CH_LF    = 8'h0A;
    localparam logic [DATA_WIDTH-1:0] CH_SP    = 8'h20;
    localparam logic [DATA_WIDTH-1:0] CH_TAB   = 8'h09;

    typedef enum logic [2:0] {
        PH_NAME  = 3'd0,
        PH_SEP   = 3'd1,
        PH_VALUE = 3'd2,
        PH_VCR   = 3'd3,
        PH_LF    = 3'd4,
        PH_FOLD  = 3'd5,
        PH_NCR   = 3'd6
    } t_phase;

    typedef enum logic [2:0] {
        K_SKIP       = 3'd0,
        K_NAME       = 3'd1,
        K_NAME_DONE  = 3'd2,
        K_VALUE      = 3'd3,
        K_VALUE_DONE = 3'd4,
        K_FOLD       = 3'd5,
        K_END        = 3'd6
    } t_kind;

    typedef enum logic [1:0] {
        OC_COMPLETE  = 2'd0,
        OC_NAMELESS  = 2'd1,
        OC_MALFORMED = 2'd2,
        OC_EARLY     = 2'd3
    } t_outcome;

    typedef enum logic [1:0] {
        ST_PRE  = 2'd0,
        ST_MAIN = 2'd1,
        ST_POST = 2'd2
    } t_step;

    // Everything one input byte causes: an optional header end before the
    // byte, the byte's own result, and an optional header end at the final byte.
    typedef struct packed {
        logic                      pre_v;
        logic [CONSUMED_WIDTH-1:0] pre_consumed;
        t_kind                     main_kind;
        logic [DATA_WIDTH-1:0]     main_data;
        t_outcome                  main_outcome;
        logic [CONSUMED_WIDTH-1:0] main_consumed;
        logic                      post_v;
        t_outcome                  post_outcome;
        logic [CONSUMED_WIDTH-1:0] post_consumed;
    } t_entry;

endpackage

// ===== design/hhlp_in_if.sv =====
// Input channel interface: one header text byte per transaction.
interface hhlp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       final_byte;

    modport source (output valid, output text_byte, output final_byte, input ready);
    modport sink (input valid, input text_byte, input final_byte, output ready);
endinterface

// ===== design/hhlp_out_if.sv =====
// Output channel interface: one parse result per transaction.
interface hhlp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  data;
    logic [1:0]  outcome;
    logic [15:0] consumed;
    logic        run_last;

    modport source (output valid, output kind, output data, output outcome,
                    output consumed, output run_last, input ready);
    modport sink (input valid, input kind, input data, input outcome,
                  input consumed, input run_last, output ready);
endinterface

// ===== design/hhlp_front.sv =====
// Front end: classifies each byte, advances the parse phase and builds a queue entry.
module hhlp_front #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    hhlp_in_if.sink           i_in,
    input  logic              i_full,
    output logic              o_push,
    output hhlp_pkg::t_entry  o_entry
);

    hhlp_pkg::t_phase         r_phase, n_phase;
    logic [COUNT_WIDTH-1:0]   r_count, n_count;
    logic [COUNT_WIDTH-1:0]   base;
    logic [COUNT_WIDTH-1:0]   bumped;
    hhlp_pkg::t_phase         eph;
    logic                     ws;
    logic                     pre;
    logic                     open;
    logic [7:0]               c;
    hhlp_pkg::t_entry         ent;

    function automatic logic [hhlp_pkg::CONSUMED_WIDTH-1:0] sat16(
        input logic [COUNT_WIDTH-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        if (w > 32'h0000_FFFF) begin
            return 16'hFFFF;
        end
        return w[15:0];
    endfunction

    assign c        = i_in.text_byte;
    assign i_in.ready = !i_full;
    assign o_push   = i_in.valid && !i_full;
    assign o_entry  = ent;

    always_comb begin
        ws      = (c == hhlp_pkg::CH_SP) || (c == hhlp_pkg::CH_TAB);
        pre     = (r_phase == hhlp_pkg::PH_LF) && !ws;
        base    = pre ? '0 : r_count;
        bumped  = (&base) ? base : base + 1'b1;
        eph     = pre ? hhlp_pkg::PH_NAME : r_phase;
        n_phase = eph;
        n_count = bumped;
        open    = 1'b1;

        ent               = '0;
        ent.pre_v         = pre;
        ent.pre_consumed  = sat16(r_count);
        ent.main_kind     = hhlp_pkg::K_SKIP;
        ent.main_outcome  = hhlp_pkg::OC_COMPLETE;
        ent.post_outcome  = hhlp_pkg::OC_COMPLETE;

        case (eph)
            hhlp_pkg::PH_SEP, hhlp_pkg::PH_VALUE, hhlp_pkg::PH_FOLD: begin
                if (c == hhlp_pkg::CH_CR) begin
                    ent.main_kind = hhlp_pkg::K_VALUE_DONE;
                    n_phase       = hhlp_pkg::PH_VCR;
                end else if ((eph != hhlp_pkg::PH_VALUE) &&
                             (ws || ((eph == hhlp_pkg::PH_SEP) &&
                                     (c == hhlp_pkg::CH_COLON)))) begin
                    ent.main_kind = hhlp_pkg::K_SKIP;
                end else begin
                    ent.main_kind = hhlp_pkg::K_VALUE;
                    ent.main_data = c;
                    n_phase       = hhlp_pkg::PH_VALUE;
                end
            end
            hhlp_pkg::PH_VCR: begin
                if (c == hhlp_pkg::CH_LF) begin
                    ent.main_kind = hhlp_pkg::K_SKIP;
                    n_phase       = hhlp_pkg::PH_LF;
                end else begin
                    ent.main_kind    = hhlp_pkg::K_END;
                    ent.main_outcome = hhlp_pkg::OC_MALFORMED;
                    n_phase          = hhlp_pkg::PH_NAME;
                    n_count          = '0;
                    open             = 1'b0;
                end
            end
            hhlp_pkg::PH_LF: begin
                ent.main_kind = hhlp_pkg::K_FOLD;
                ent.main_data = hhlp_pkg::CH_SP;
                n_phase       = hhlp_pkg::PH_FOLD;
            end
            hhlp_pkg::PH_NCR: begin
                ent.main_kind = hhlp_pkg::K_END;
                if (c == hhlp_pkg::CH_LF) begin
                    ent.main_outcome  = hhlp_pkg::OC_NAMELESS;
                    ent.main_consumed = sat16(bumped);
                end else begin
                    ent.main_outcome = hhlp_pkg::OC_MALFORMED;
                end
                n_phase = hhlp_pkg::PH_NAME;
                n_count = '0;
                open    = 1'b0;
            end
            default: begin
                if ((c == hhlp_pkg::CH_COLON) || ws) begin
                    ent.main_kind = hhlp_pkg::K_NAME_DONE;
                    n_phase       = hhlp_pkg::PH_SEP;
                end else if (c == hhlp_pkg::CH_CR) begin
                    ent.main_kind = hhlp_pkg::K_SKIP;
                    n_phase       = hhlp_pkg::PH_NCR;
                end else begin
                    ent.main_kind = hhlp_pkg::K_NAME;
                    ent.main_data = c;
                    n_phase       = hhlp_pkg::PH_NAME;
                end
            end
        endcase

        if (i_in.final_byte && open) begin
            ent.post_v = 1'b1;
            if (n_phase == hhlp_pkg::PH_LF) begin
                ent.post_outcome  = hhlp_pkg::OC_COMPLETE;
                ent.post_consumed = sat16(bumped);
            end else if ((n_phase == hhlp_pkg::PH_VCR) || (n_phase == hhlp_pkg::PH_NCR)) begin
                ent.post_outcome = hhlp_pkg::OC_MALFORMED;
            end else begin
                ent.post_outcome  = hhlp_pkg::OC_EARLY;
                ent.post_consumed = sat16(bumped);
            end
            n_phase = hhlp_pkg::PH_NAME;
            n_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= hhlp_pkg::PH_NAME;
            r_count <= '0;
        end else if (o_push) begin
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

endmodule

// ===== design/hhlp_queue.sv =====
// Short queue of parsed entries between the front end and the result sequencer.
module hhlp_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  hhlp_pkg::t_entry  i_entry,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_empty,
    output hhlp_pkg::t_entry  o_head
);

    hhlp_pkg::t_entry                r_mem [hhlp_pkg::QUEUE_DEPTH];
    logic [hhlp_pkg::QUEUE_AW-1:0]   r_wr;
    logic [hhlp_pkg::QUEUE_AW-1:0]   r_rd;
    logic [hhlp_pkg::QUEUE_AW:0]     r_cnt;

    assign o_full  = (r_cnt == (hhlp_pkg::QUEUE_AW+1)'(hhlp_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== design/hhlp_back.sv =====
// Back end: plays out each queued entry's results, one per cycle unless the output stalls, into the output register.
module hhlp_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  hhlp_pkg::t_entry  i_head,
    output logic              o_pop,
    hhlp_out_if.source        o_out
);

    hhlp_pkg::t_step    r_step, n_step;
    hhlp_pkg::t_step    eff;
    logic               load;
    logic               is_last;
    logic               r_valid;
    hhlp_pkg::t_kind    r_kind, n_kind;
    logic [7:0]         r_data, n_data;
    hhlp_pkg::t_outcome r_outcome, n_outcome;
    logic [15:0]        r_consumed, n_consumed;
    logic               r_run_last;

    assign load  = !i_empty && (!r_valid || o_out.ready);
    assign o_pop = load && is_last;

    always_comb begin
        eff = r_step;
        if ((r_step == hhlp_pkg::ST_PRE) && !i_head.pre_v) begin
            eff = hhlp_pkg::ST_MAIN;
        end
        n_kind     = hhlp_pkg::K_END;
        n_data     = '0;
        n_outcome  = hhlp_pkg::OC_COMPLETE;
        n_consumed = '0;
        is_last    = 1'b0;
        case (eff)
            hhlp_pkg::ST_PRE: begin
                n_consumed = i_head.pre_consumed;
            end
            hhlp_pkg::ST_MAIN: begin
                n_kind     = i_head.main_kind;
                n_data     = i_head.main_data;
                n_outcome  = i_head.main_outcome;
                n_consumed = i_head.main_consumed;
                is_last    = !i_head.post_v;
            end
            default: begin
                n_outcome  = i_head.post_outcome;
                n_consumed = i_head.post_consumed;
                is_last    = 1'b1;
            end
        endcase

        n_step = r_step;
        if (load) begin
            if (is_last) begin
                n_step = hhlp_pkg::ST_PRE;
            end else if (eff == hhlp_pkg::ST_PRE) begin
                n_step = hhlp_pkg::ST_MAIN;
            end else begin
                n_step = hhlp_pkg::ST_POST;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_step  <= hhlp_pkg::ST_PRE;
        end else begin
            r_step <= n_step;
            if (load) begin
                r_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind     <= n_kind;
            r_data     <= n_data;
            r_outcome  <= n_outcome;
            r_consumed <= n_consumed;
            r_run_last <= is_last;
        end
    end

    assign o_out.valid    = r_valid;
    assign o_out.kind     = r_kind;
    assign o_out.data     = r_data;
    assign o_out.outcome  = r_outcome;
    assign o_out.consumed = r_consumed;
    assign o_out.run_last = r_run_last;

endmodule

// ===== design/http_header_line_parser.sv =====
// Top level of the HTTP header line parser: front end, entry queue and result sequencer.
//
//  Port    Direction  Payload                                    Per transaction
//  i_in    sink       text_byte[7:0], final_byte                 one header text byte
//  o_out   source     kind[2:0], data[7:0], outcome[1:0],        one parse result
//                     consumed[15:0], run_last
//
// A byte is classified in the cycle it is taken and its one to three results
// join a four-entry queue; the sequencer then emits one result per cycle
// while o_out is ready. Bytes causing a single result then flow at one per
// cycle; a byte that ends a header as well adds one result for each header end.
// The input stalls only when the queue is full. Reset is synchronous and
// returns the parser to the name phase with a zero byte count.
module http_header_line_parser #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hhlp_in_if.sink     i_in,
    hhlp_out_if.source  o_out
);

    logic              push;
    logic              pop;
    logic              full;
    logic              empty;
    hhlp_pkg::t_entry  entry;
    hhlp_pkg::t_entry  head;

    hhlp_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_entry (entry)
    );

    hhlp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    hhlp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_head  (head),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

// ===== tb/http_header_line_parser_test.sv =====
// Self-checking testbench for the HTTP header line parser, with its own predictor and result checks.
module http_header_line_parser_test;
    timeunit 1ns;
    timeprecision 1ps;

    import hhlp_pkg::*;

    typedef struct {
        t_kind       kind;
        logic [7:0]  data;
        t_outcome    outcome;
        logic [15:0] consumed;
        logic        run_last;
    } parse_result_t;

    typedef struct {
        logic [7:0]  text;
        logic        last;
        bit          typed;
        int          typed_idx;
        t_kind       kind;
        logic [7:0]  data;
        t_outcome    outcome;
        logic [15:0] consumed;
    } stim_row_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    hhlp_in_if  in_if ();
    hhlp_out_if out_if ();

    http_header_line_parser dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_phase        model_phase = PH_NAME;
    logic [15:0]   model_count = '0;
    parse_result_t step_results[$];
    parse_result_t pending_results[$];

    int fail_count   = 0;
    int bytes_sent   = 0;
    int results_seen = 0;
    int ends_by_outcome [4] = '{0, 0, 0, 0};
    bit tx_idle      = 1'b0;
    bit rx_idle      = 1'b0;
    int rx_hold      = 0;
    int final_odds   = 0;

    // Typed rows give the expected result at typed_idx among those the byte causes.
    stim_row_t directed_rows [25] = '{
        '{8'h48,    1'b0, 1'b1, 0, K_NAME,       8'h48, OC_COMPLETE,  16'd0},
        '{CH_COLON, 1'b0, 1'b0, 0, K_SKIP,       8'h00, OC_COMPLETE,  16'd0},
        '{CH_SP,    1'b0, 1'b0, 0, K_SKIP,       8'h00, OC_COMPLETE,  16'd0},
        '{8'hFF,    1'b0, 1'b1, 0, K_VALUE,      8'hFF, OC_COMPLETE,  16'd0},
        '{8'h00,    1'b0, 1'b1, 0, K_VALUE,      8'h00, OC_COMPLETE,  16'd0},
        '{CH_CR,    1'b0, 1'b0, 0, K_SKIP,       8'h00, OC_COMPLETE,  16'd0},
        '{CH_LF,    1'b0, 1'b0, 0, K_SKIP,       8'h00, OC_COMPLETE,  16'd0},
        '{CH_TAB,   1'b0, 1'b1, 0, K_FOLD,       CH_SP, OC_COMPLETE,  16'd0},
        '{CH_SP,    1'b0, 1'b0, 0, K_SKIP,       8'h00, OC_COMPLETE,  16'd0},
        '{CH_CR,    1'b0, 1'b1, 0, K_VALUE_DONE, 8'h00, OC_COMPLETE,  16'd0},
        '{CH_LF,    1'b0, 1'b0, 0, K_SKIP,       8'h00, OC_COMPLETE,  16'd0},
        '{8'h41,    1'b0, 1'b1, 0, K_END,        8'h00, OC_COMPLETE,  16'd11},
        '{CH_CR,    1'b0, 1'b0, 0, K_SKIP,       8'h00, OC_COMPLETE,  16'd0},
        '{CH_LF,    1'b0, 1'b1, 0, K_END,        8'h00, OC_NAMELESS,  16'd3},
        '{CH_CR,    1'b0, 1'b0, 0, K_SKIP,       8'h00, OC_COMPLETE,  16'd0},
        '{CH_LF,    1'b0, 1'b1, 0, K_END,        8'h00, OC_NAMELESS,  16'd2},
        '{8'h42,    1'b0, 1'b0, 0, K_SKIP,       8'h00, OC_COMPLETE,  16'd0},
        '{CH_CR,    1'b0, 1'b0, 0, K_SKIP,       8'h00, OC_COMPLETE,  16'd0},
        '{8'h78,    1'b0, 1'b1, 0, K_END,        8'h00, OC_MALFORMED, 16'd0},
        '{CH_COLON, 1'b0, 1'b0, 0, K_SKIP,       8'h00, OC_COMPLETE,  16'd0},
        '{8'h76,    1'b0, 1'b0, 0, K_SKIP,       8'h00, OC_COMPLETE,  16'd0},
        '{CH_CR,    1'b0, 1'b0, 0, K_SKIP,       8'h00, OC_COMPLETE,  16'd0},
        '{CH_LF,    1'b1, 1'b1, 1, K_END,        8'h00, OC_COMPLETE,  16'd4},
        '{8'h6B,    1'b1, 1'b1, 1, K_END,        8'h00, OC_EARLY,     16'd1},
        '{CH_CR,    1'b1, 1'b1, 1, K_END,        8'h00, OC_MALFORMED, 16'd0}
    };

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic bit is_blank(input logic [7:0] c);
        return c == CH_SP || c == CH_TAB;
    endfunction

    function automatic void add_result(input t_kind kind, input logic [7:0] data,
                                       input t_outcome outcome, input logic [15:0] consumed);
        step_results.push_back('{kind, data, outcome, consumed, 1'b0});
    endfunction

    function automatic void close_header(input t_outcome outcome);
        add_result(K_END, 8'h00, outcome, outcome == OC_MALFORMED ? 16'd0 : model_count);
        model_phase = PH_NAME;
        model_count = '0;
    endfunction

    function automatic void parse_byte(input logic [7:0] c, input logic last);
        t_phase ph;
        bit     open;
        step_results.delete();
        open = 1'b1;
        ph   = model_phase;
        if (ph == PH_LF && !is_blank(c)) begin
            close_header(OC_COMPLETE);
            ph = PH_NAME;
        end
        if (model_count != 16'hFFFF) model_count++;
        case (ph)
            PH_SEP, PH_VALUE, PH_FOLD: begin
                if (ph != PH_VALUE && (is_blank(c) || (ph == PH_SEP && c == CH_COLON))) begin
                    add_result(K_SKIP, 8'h00, OC_COMPLETE, 16'd0);
                end else if (c == CH_CR) begin
                    add_result(K_VALUE_DONE, 8'h00, OC_COMPLETE, 16'd0);
                    model_phase = PH_VCR;
                end else begin
                    add_result(K_VALUE, c, OC_COMPLETE, 16'd0);
                    model_phase = PH_VALUE;
                end
            end
            PH_VCR: begin
                if (c == CH_LF) begin
                    add_result(K_SKIP, 8'h00, OC_COMPLETE, 16'd0);
                    model_phase = PH_LF;
                end else begin
                    close_header(OC_MALFORMED);
                    open = 1'b0;
                end
            end
            PH_LF: begin
                add_result(K_FOLD, CH_SP, OC_COMPLETE, 16'd0);
                model_phase = PH_FOLD;
            end
            PH_NCR: begin
                close_header(c == CH_LF ? OC_NAMELESS : OC_MALFORMED);
                open = 1'b0;
            end
            default: begin
                if (c == CH_COLON || is_blank(c)) begin
                    add_result(K_NAME_DONE, 8'h00, OC_COMPLETE, 16'd0);
                    model_phase = PH_SEP;
                end else if (c == CH_CR) begin
                    add_result(K_SKIP, 8'h00, OC_COMPLETE, 16'd0);
                    model_phase = PH_NCR;
                end else begin
                    add_result(K_NAME, c, OC_COMPLETE, 16'd0);
                    model_phase = PH_NAME;
                end
            end
        endcase
        if (last && open) begin
            case (model_phase)
                PH_LF:          close_header(OC_COMPLETE);
                PH_VCR, PH_NCR: close_header(OC_MALFORMED);
                default:        close_header(OC_EARLY);
            endcase
        end
        step_results[step_results.size() - 1].run_last = 1'b1;
    endfunction

    // Offers one byte, and once the transaction completes records what it should produce.
    task automatic send_byte(input stim_row_t row);
        int gap;
        gap = tx_idle ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.text_byte  <= row.text;
        in_if.final_byte <= row.last;
        do @(posedge i_clk); while (!in_if.ready);
        parse_byte(row.text, row.last);
        if (row.typed) begin
            step_results[row.typed_idx].kind     = row.kind;
            step_results[row.typed_idx].data     = row.data;
            step_results[row.typed_idx].outcome  = row.outcome;
            step_results[row.typed_idx].consumed = row.consumed;
        end
        foreach (step_results[i]) pending_results.push_back(step_results[i]);
        bytes_sent++;
    endtask

    task automatic send_text(input logic [7:0] c, input logic last);
        send_byte('{c, last, 1'b0, 0, K_SKIP, 8'h00, OC_COMPLETE, 16'd0});
    endtask

    task automatic send_plain(input logic [7:0] c);
        send_text(c, final_odds > 0 && $urandom_range(1, final_odds) == 1);
    endtask

    function automatic logic [7:0] name_char();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255));
        while (c == CH_COLON || c == CH_CR || is_blank(c));
        return c;
    endfunction

    function automatic logic [7:0] value_char();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (c == CH_CR);
        return c;
    endfunction

    function automatic logic [7:0] sep_char();
        case ($urandom_range(0, 2))
            0:       return CH_COLON;
            1:       return CH_SP;
            default: return CH_TAB;
        endcase
    endfunction

    task automatic emit_header();
        repeat ($urandom_range(0, 5)) send_plain(name_char());
        send_plain(sep_char());
        repeat ($urandom_range(0, 2)) send_plain(sep_char());
        repeat ($urandom_range(0, 6)) send_plain(value_char());
        send_plain(CH_CR);
        send_plain(CH_LF);
        while ($urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 2)) send_plain($urandom_range(0, 1) ? CH_SP : CH_TAB);
            repeat ($urandom_range(0, 4)) send_plain(value_char());
            send_plain(CH_CR);
            send_plain(CH_LF);
        end
    endtask

    function automatic void check_field(input string field, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        parse_result_t want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            results_seen++;
            if (out_if.kind == K_END) ends_by_outcome[out_if.outcome]++;
            if (pending_results.size() == 0) begin
                $display("%0t: expected no result, got kind %0d data %0h", $time,
                         out_if.kind, out_if.data);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("kind", 16'(want.kind), 16'(out_if.kind));
                check_field("data", 16'(want.data), 16'(out_if.data));
                check_field("outcome", 16'(want.outcome), 16'(out_if.outcome));
                check_field("consumed", want.consumed, out_if.consumed);
                check_field("run_last", 16'(want.run_last), 16'(out_if.run_last));
            end
        end
    end

    initial begin
        int stall;
        out_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (rx_hold > 0) begin
                out_if.ready <= 1'b0;
                repeat (rx_hold) @(posedge i_clk);
                rx_hold = 0;
            end else begin
                stall = rx_idle ? $urandom_range(0, 15) : 0;
                if (stall > 0) begin
                    out_if.ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!out_if.valid);
        end
    end

    initial begin
        int target;
        i_rst_n          <= 1'b0;
        in_if.valid      <= 1'b0;
        in_if.text_byte  <= '0;
        in_if.final_byte <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) send_byte(directed_rows[i]);
        in_if.valid <= 1'b0;
        wait (pending_results.size() == 0);

        // The receiver stalls for a long stretch so that the queue fills and the input backs up.
        rx_hold = 48;
        emit_header();
        emit_header();
        emit_header();

        final_odds = 24;
        target = bytes_sent + 260;
        while (bytes_sent < target) begin
            if ($urandom_range(0, 7) == 0) begin
                tx_idle = 1'($urandom_range(0, 1));
                rx_idle = 1'($urandom_range(0, 1));
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: emit_header();
                6: begin
                    send_plain(CH_CR);
                    send_plain(CH_LF);
                end
                7: begin
                    repeat ($urandom_range(0, 3)) send_plain(name_char());
                    if ($urandom_range(0, 1)) begin
                        send_plain(CH_COLON);
                        repeat ($urandom_range(0, 3)) send_plain(value_char());
                    end
                    send_plain(CH_CR);
                    send_plain($urandom_range(0, 1) ? value_char() : CH_CR);
                end
                8: repeat ($urandom_range(1, 4)) send_plain(8'($urandom_range(0, 255)));
                default: begin
                    repeat ($urandom_range(1, 3)) send_plain(name_char());
                    send_plain(CH_COLON);
                    repeat ($urandom_range(0, 3)) send_plain(value_char());
                    send_plain(CH_CR);
                    send_plain(CH_LF);
                    send_text(name_char(), 1'b1);
                end
            endcase
        end
        in_if.valid <= 1'b0;

        wait (pending_results.size() == 0);
        repeat (8) @(posedge i_clk);
        $display("Sent %0d header bytes (directed, back-pressure, random);",
                 bytes_sent);
        $display("checked %0d results: %0d complete, %0d nameless, %0d malformed, %0d cut short.",
                 results_seen, ends_by_outcome[0], ends_by_outcome[1], ends_by_outcome[2],
                 ends_by_outcome[3]);
        if (fail_count == 0) begin
            $display("http_header_line_parser_test OK");
        end else begin
            $display("http_header_line_parser_test NOT OK");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("http_header_line_parser_test NOT OK");
        $finish;
    end

endmodule
